// ----- src/waypoint_turn_then_drive_steering_unit_defines.svh -----
// ----------------------------------------------------------------------------
// waypoint steering assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef WAYPOINT_TURN_THEN_DRIVE_STEERING_UNIT_DEFINES_SVH
`define WAYPOINT_TURN_THEN_DRIVE_STEERING_UNIT_DEFINES_SVH

// same-cycle implication
`define WST_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define WST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/wst_pkg.sv -----
// ----------------------------------------------------------------------------
// waypoint steering package
// shared types, constants and the cordic arctangent table
// ----------------------------------------------------------------------------
package wst_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int TABLE_LEN = 24;
	localparam int GUARD_BITS = 8;
	// datapath width of the cordic x and y words, covers the gain growth
	localparam int XW = 28;
	localparam logic [23:0] INV_GAIN_Q24 = 24'd10188014;
	localparam logic [16:0] DIST_MAX = 17'd92682;

	typedef enum logic [1:0] {
		CMD_LEFT    = 2'd0,
		CMD_RIGHT   = 2'd1,
		CMD_FORWARD = 2'd2,
		CMD_STOP    = 2'd3
	} steer_cmd_t;

	typedef enum logic [1:0] {
		REG_TURN_THRESHOLD = 2'd0,
		REG_STOP_DISTANCE  = 2'd1,
		REG_FORWARD_SPEED  = 2'd2,
		REG_TURN_SPEED     = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [14:0] turn_threshold;
		logic [16:0] stop_distance;
		logic [14:0] forward_speed;
		logic [14:0] turn_speed;
	} cfg_t;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic        [31:0]   z;
		logic                 zero;
		logic signed [15:0]   heading;
	} cordic_t;

	typedef struct packed {
		steer_cmd_t         cmd;
		logic [14:0]        lin;
		logic signed [15:0] ang;
		logic signed [15:0] err;
		logic [16:0]        goal_dist;
	} result_t;

	// round(atan(2^-i) * 2^32 / (2 pi))
	function automatic logic [31:0] atan_entry(input logic [4:0] idx);
		logic [31:0] v;
		case (idx)
			5'd0:    v = 32'd536870912;
			5'd1:    v = 32'd316933406;
			5'd2:    v = 32'd167458907;
			5'd3:    v = 32'd85004756;
			5'd4:    v = 32'd42667331;
			5'd5:    v = 32'd21354465;
			5'd6:    v = 32'd10679838;
			5'd7:    v = 32'd5340245;
			5'd8:    v = 32'd2670163;
			5'd9:    v = 32'd1335087;
			5'd10:   v = 32'd667544;
			5'd11:   v = 32'd333772;
			5'd12:   v = 32'd166886;
			5'd13:   v = 32'd83443;
			5'd14:   v = 32'd41722;
			5'd15:   v = 32'd20861;
			5'd16:   v = 32'd10430;
			5'd17:   v = 32'd5215;
			5'd18:   v = 32'd2608;
			5'd19:   v = 32'd1304;
			5'd20:   v = 32'd652;
			5'd21:   v = 32'd326;
			5'd22:   v = 32'd163;
			5'd23:   v = 32'd81;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

// ----- src/waypoint_turn_then_drive_steering_unit.sv -----
// path: front end, CORDIC_STAGES cordic stages and back end between input request and result
// throughput: one request per cycle while the result channel is not stalled, set by the fully unrolled cordic pipeline
// each stage holds its own valid bit, so bubbles close up behind a stalled output
// reset: arst_n clears every valid bit at once and loads the register defaults
// ----------------------------------------------------------------------------
// waypoint turn-then-drive steering unit
// go-to-goal controller: cordic bearing and distance, then a steering decision
// ----------------------------------------------------------------------------
module waypoint_turn_then_drive_steering_unit import wst_pkg::*; #(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input request channel
	input  logic        s_tvalid,
	output logic        s_tready,
	// robot_pos_x, robot_pos_y, robot_heading, goal_x, goal_y (16 bits each)
	input  logic [79:0] s_tdata,
	// result channel
	output logic        m_tvalid,
	input  logic        m_tready,
	// steer_command[1:0], linear_speed[16:2], angular_speed[32:17],
	// heading_error[48:33], goal_distance[65:49], zero fill
	output logic [71:0] m_tdata,
	// register write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [16:0] cfg_wdata
);

	cfg_t    cfg_q;
	cordic_t c_data  [CORDIC_STAGES+1];
	logic    c_valid [CORDIC_STAGES+1];
	logic    c_ready [CORDIC_STAGES+1];
	result_t res;

	// register file; the user must write it only while idle, the block itself does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.turn_threshold <= 15'd209;
			cfg_q.stop_distance  <= 17'd77;
			cfg_q.forward_speed  <= 15'd179;
			cfg_q.turn_speed     <= 15'd205;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_TURN_THRESHOLD: cfg_q.turn_threshold <= cfg_wdata[14:0];
				REG_STOP_DISTANCE:  cfg_q.stop_distance  <= cfg_wdata;
				REG_FORWARD_SPEED:  cfg_q.forward_speed  <= cfg_wdata[14:0];
				REG_TURN_SPEED:     cfg_q.turn_speed     <= cfg_wdata[14:0];
				default: ;
			endcase
		end
	end

	// offset to goal and pre-rotation, two stages
	wst_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.pos_x     ($signed(s_tdata[15:0])),
		.pos_y     ($signed(s_tdata[31:16])),
		.heading   ($signed(s_tdata[47:32])),
		.goal_x    ($signed(s_tdata[63:48])),
		.goal_y    ($signed(s_tdata[79:64])),
		.out_valid (c_valid[0]),
		.out_ready (c_ready[0]),
		.out_data  (c_data[0])
	);

	// one registered micro-rotation per stage
	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
		wst_cordic_stage #(
			.STAGE (g)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (c_valid[g]),
			.in_ready  (c_ready[g]),
			.in_data   (c_data[g]),
			.out_valid (c_valid[g+1]),
			.out_ready (c_ready[g+1]),
			.out_data  (c_data[g+1])
		);
	end

	// gain multiply, rounding and decision, three stages; last one is the output register
	wst_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (c_valid[CORDIC_STAGES]),
		.in_ready  (c_ready[CORDIC_STAGES]),
		.in_data   (c_data[CORDIC_STAGES]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (res)
	);

	assign m_tdata = {6'b0, res.goal_dist, res.err, res.ang, res.lin, res.cmd};

endmodule

// ----- src/wst_front.sv -----
// ----------------------------------------------------------------------------
// waypoint steering front end
// offset to goal, then half-turn pre-rotation into the cordic format
// ----------------------------------------------------------------------------
module wst_front import wst_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic signed [15:0] heading,
	input  logic signed [15:0] goal_x,
	input  logic signed [15:0] goal_y,
	output logic               out_valid,
	input  logic               out_ready,
	output cordic_t            out_data
);

	logic               v_s1;
	logic signed [16:0] dx_s1;
	logic signed [16:0] dy_s1;
	logic signed [15:0] hd_s1;
	logic               en_s2;
	logic               v_s2;
	cordic_t            d_s2;
	logic signed [XW-1:0] x_ext;
	logic signed [XW-1:0] y_ext;

	assign en_s2    = !v_s2 || out_ready;
	assign in_ready = !v_s1 || en_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			dx_s1 <= 17'(goal_x) - 17'(pos_x);
			dy_s1 <= 17'(goal_y) - 17'(pos_y);
			hd_s1 <= heading;
		end
	end

	// guard fraction bits below the offset, sign carried into the top bits
	assign x_ext = XW'($signed({dx_s1, {GUARD_BITS{1'b0}}}));
	assign y_ext = XW'($signed({dy_s1, {GUARD_BITS{1'b0}}}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && en_s2) begin
			// left half plane: turn by half a turn first
			if (dx_s1[16]) begin
				d_s2.x <= -x_ext;
				d_s2.y <= -y_ext;
				d_s2.z <= 32'h8000_0000;
			end else begin
				d_s2.x <= x_ext;
				d_s2.y <= y_ext;
				d_s2.z <= 32'h0;
			end
			d_s2.zero    <= (dx_s1 == 17'sd0) && (dy_s1 == 17'sd0);
			d_s2.heading <= hd_s1;
		end
	end

	assign out_valid = v_s2;
	assign out_data  = d_s2;

endmodule

// ----- src/wst_cordic_stage.sv -----
// ----------------------------------------------------------------------------
// waypoint steering cordic stage
// one registered vectoring micro-rotation
// ----------------------------------------------------------------------------
module wst_cordic_stage import wst_pkg::*; #(
	parameter int STAGE = 0
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  cordic_t in_data,
	output logic    out_valid,
	input  logic    out_ready,
	output cordic_t out_data
);

	localparam logic [31:0] ATAN = atan_entry(5'(STAGE));

	logic                 v_s1;
	cordic_t              d_s1;
	logic signed [XW-1:0] xs;
	logic signed [XW-1:0] ys;

	assign in_ready = !v_s1 || out_ready;

	// arithmetic shift rounds toward minus infinity
	assign xs = in_data.x >>> STAGE;
	assign ys = in_data.y >>> STAGE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			if (!in_data.y[XW-1]) begin
				d_s1.x <= in_data.x + ys;
				d_s1.y <= in_data.y - xs;
				d_s1.z <= in_data.z + ATAN;
			end else begin
				d_s1.x <= in_data.x - ys;
				d_s1.y <= in_data.y + xs;
				d_s1.z <= in_data.z - ATAN;
			end
			d_s1.zero    <= in_data.zero;
			d_s1.heading <= in_data.heading;
		end
	end

	assign out_valid = v_s1;
	assign out_data  = d_s1;

endmodule

// ----- src/wst_back.sv -----
// ----------------------------------------------------------------------------
// waypoint steering back end
// gain correction, heading error and the steering decision
// ----------------------------------------------------------------------------
module wst_back import wst_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    in_valid,
	output logic    in_ready,
	input  cordic_t in_data,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	localparam int PW = XW - 1 + 24;
	localparam int DW = PW - 32 + 1;

	logic               en_s1, en_s2, en_s3;
	logic               v_s1, v_s2, v_s3;
	logic [XW-2:0]      xc;
	logic [15:0]        bearing;
	logic [PW-1:0]      prod_s1;
	logic signed [15:0] err_s1;
	logic               zero_s1;
	logic [DW-1:0]      dsum;
	logic [16:0]        dist_s2;
	logic signed [15:0] err_s2;
	logic signed [16:0] err_x;
	logic signed [16:0] thr_pos;
	result_t            res;
	result_t            d_s3;

	assign en_s3    = !v_s3 || out_ready;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	assign xc      = in_data.x[XW-1] ? '0 : in_data.x[XW-2:0];
	// round the angle accumulator to 16 bits, half up
	assign bearing = in_data.zero ? 16'h0 : in_data.z[31:16] + 16'(in_data.z[15]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && en_s1) begin
			prod_s1 <= PW'(xc) * PW'(INV_GAIN_Q24);
			err_s1  <= $signed(bearing - in_data.heading);
			zero_s1 <= in_data.zero;
		end
	end

	assign dsum = {1'b0, prod_s1[PW-1:32]} + DW'(prod_s1[31]);

	always_ff @(posedge clk) begin
		if (v_s1 && en_s2) begin
			if (zero_s1) begin
				dist_s2 <= 17'd0;
			end else if (dsum > DW'(DIST_MAX)) begin
				dist_s2 <= DIST_MAX;
			end else begin
				dist_s2 <= dsum[16:0];
			end
			err_s2 <= err_s1;
		end
	end

	assign err_x   = 17'(err_s2);
	assign thr_pos = $signed({2'b00, cfg.turn_threshold});

	always_comb begin
		res.err       = err_s2;
		res.goal_dist = dist_s2;
		res.lin       = 15'd0;
		res.ang       = 16'sd0;
		if (err_x > thr_pos) begin
			res.cmd = CMD_LEFT;
			res.ang = $signed({1'b0, cfg.turn_speed});
		end else if (err_x < -thr_pos) begin
			res.cmd = CMD_RIGHT;
			res.ang = -$signed({1'b0, cfg.turn_speed});
		end else if (dist_s2 > cfg.stop_distance) begin
			res.cmd = CMD_FORWARD;
			res.lin = cfg.forward_speed;
		end else begin
			res.cmd = CMD_STOP;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2 && en_s3) begin
			d_s3 <= res;
		end
	end

	assign out_valid = v_s3;
	assign out_data  = d_s3;

endmodule

// ----- src/wst_checker.sv -----
// ----------------------------------------------------------------------------
// waypoint steering port checker
// properties on the top level ports, bound to the unit
// ----------------------------------------------------------------------------
`include "waypoint_turn_then_drive_steering_unit_defines.svh"

module wst_checker import wst_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata
);

	logic [1:0]         cmd;
	logic [14:0]        lin;
	logic signed [15:0] ang;
	logic signed [15:0] err;
	logic [16:0]        goal_dist;

	assign cmd       = m_tdata[1:0];
	assign lin       = m_tdata[16:2];
	assign ang       = $signed(m_tdata[32:17]);
	assign err       = $signed(m_tdata[48:33]);
	assign goal_dist = m_tdata[65:49];

	// a stalled result holds
	`WST_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
	// with nothing waiting at the output the pipeline takes a request
	`WST_ASSERT_NOW(a_empty_ready, clk, arst_n, !m_tvalid, s_tready, "input not ready with empty output")
	// turning commands agree with the sign of the error and carry no linear speed
	`WST_ASSERT_NOW(a_turn_sign, clk, arst_n, m_tvalid && (cmd == CMD_LEFT || cmd == CMD_RIGHT), lin == 15'd0 && ((cmd == CMD_LEFT) ? (err > 16'sd0) : (err < 16'sd0)), "turn command inconsistent with error")
	// distance saturates and straight commands never turn
	`WST_ASSERT_NOW(a_straight, clk, arst_n, m_tvalid && (cmd == CMD_FORWARD || cmd == CMD_STOP), ang == 16'sd0 && goal_dist <= DIST_MAX && (cmd == CMD_FORWARD || lin == 15'd0), "straight command inconsistent")

endmodule

bind waypoint_turn_then_drive_steering_unit wst_checker u_wst_checker (.*);

// ----- bench/steering_result_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// steering result checker
// predicts each steering result from the accepted pose request and the
// register values, then compares it field by field with the result channel
// ----------------------------------------------------------------------------
module steering_result_checker import wst_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	// robot_pos_x, robot_pos_y, robot_heading, goal_x, goal_y (16 bits each)
	input  logic [79:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	// steer_command, linear_speed, angular_speed, heading_error, goal_distance
	input  logic [71:0] m_tdata,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [16:0] cfg_wdata,
	output int          fail_count,
	output int          waiting,
	output int          checked
);

	localparam logic [14:0] RST_TURN_THRESHOLD = 15'd209;
	localparam logic [16:0] RST_STOP_DISTANCE  = 17'd77;
	localparam logic [14:0] RST_FORWARD_SPEED  = 15'd179;
	localparam logic [14:0] RST_TURN_SPEED     = 15'd205;

	cfg_t    steer_cfg;
	result_t due_q[$];
	result_t due;

	// arctangent of 2^-stage as a fraction of a full turn, 2^32 per turn
	function automatic logic [31:0] atan_turn(input int stage);
		case (stage)
			0:       return 32'd536870912;
			1:       return 32'd316933406;
			2:       return 32'd167458907;
			3:       return 32'd85004756;
			4:       return 32'd42667331;
			5:       return 32'd21354465;
			6:       return 32'd10679838;
			7:       return 32'd5340245;
			8:       return 32'd2670163;
			9:       return 32'd1335087;
			10:      return 32'd667544;
			11:      return 32'd333772;
			12:      return 32'd166886;
			13:      return 32'd83443;
			14:      return 32'd41722;
			15:      return 32'd20861;
			16:      return 32'd10430;
			17:      return 32'd5215;
			18:      return 32'd2608;
			19:      return 32'd1304;
			20:      return 32'd652;
			21:      return 32'd326;
			22:      return 32'd163;
			23:      return 32'd81;
			default: return 32'd0;
		endcase
	endfunction

	function automatic result_t predict_steering(input logic [79:0] pose, input cfg_t c);
		longint             dx, dy, x, y, xs, ys;
		longint unsigned    prod;
		logic [31:0]        z, zr;
		logic [15:0]        bearing;
		logic [16:0]        goal_dist;
		logic signed [15:0] err;
		int                 thr;
		int                 i;
		result_t            r;
		dx = longint'($signed(pose[63:48])) - longint'($signed(pose[15:0]));
		dy = longint'($signed(pose[79:64])) - longint'($signed(pose[31:16]));
		bearing = '0;
		goal_dist = '0;
		// goal on the robot leaves bearing and distance at zero
		if (dx != 0 || dy != 0) begin
			x = dx * (1 << GUARD_BITS);
			y = dy * (1 << GUARD_BITS);
			z = '0;
			// left half plane: swing round by half a turn first
			if (x < 0) begin
				x = -x;
				y = -y;
				z = 32'h8000_0000;
			end
			for (i = 0; i < CORDIC_STAGES_DEF && i < TABLE_LEN; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y >= 0) begin
					x = x + ys;
					y = y - xs;
					z = z + atan_turn(i);
				end else begin
					x = x - ys;
					y = y + xs;
					z = z - atan_turn(i);
				end
			end
			zr = z + 32'h0000_8000;
			bearing = zr[31:16];
			if (x < 0)
				x = 0;
			prod = ($unsigned(x) * 64'(INV_GAIN_Q24) + 64'h8000_0000) >> 32;
			goal_dist = (prod > 64'(DIST_MAX)) ? DIST_MAX : prod[16:0];
		end
		err = bearing - pose[47:32];
		thr = int'(c.turn_threshold);
		r.lin = '0;
		r.ang = '0;
		r.err = err;
		r.goal_dist = goal_dist;
		if (int'(err) > thr) begin
			r.cmd = CMD_LEFT;
			r.ang = {1'b0, c.turn_speed};
		end else if (int'(err) < -thr) begin
			r.cmd = CMD_RIGHT;
			r.ang = 16'd0 - {1'b0, c.turn_speed};
		end else if (goal_dist > c.stop_distance) begin
			r.cmd = CMD_FORWARD;
			r.lin = c.forward_speed;
		end else begin
			r.cmd = CMD_STOP;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steer_cfg.turn_threshold = RST_TURN_THRESHOLD;
			steer_cfg.stop_distance = RST_STOP_DISTANCE;
			steer_cfg.forward_speed = RST_FORWARD_SPEED;
			steer_cfg.turn_speed = RST_TURN_SPEED;
			due_q.delete();
			fail_count = 0;
			checked = 0;
			waiting = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (due_q.size() == 0) begin
					$error("result with no request outstanding: %h", m_tdata);
					fail_count++;
				end else begin
					due = due_q[0];
					due_q.delete(0);
					if (m_tdata[1:0] !== due.cmd) begin
						$error("steer_command: expected %0d, got %0d", due.cmd, m_tdata[1:0]);
						fail_count++;
					end
					if (m_tdata[16:2] !== due.lin) begin
						$error("linear_speed: expected %0d, got %0d", due.lin, m_tdata[16:2]);
						fail_count++;
					end
					if (m_tdata[32:17] !== due.ang) begin
						$error("angular_speed: expected %0d, got %0d",
							$signed(due.ang), $signed(m_tdata[32:17]));
						fail_count++;
					end
					if (m_tdata[48:33] !== due.err) begin
						$error("heading_error: expected %0d, got %0d",
							$signed(due.err), $signed(m_tdata[48:33]));
						fail_count++;
					end
					if (m_tdata[65:49] !== due.goal_dist) begin
						$error("goal_distance: expected %0d, got %0d", due.goal_dist,
							m_tdata[65:49]);
						fail_count++;
					end
				end
				checked++;
			end
			if (s_tvalid && s_tready)
				due_q.insert(due_q.size(), predict_steering(s_tdata, steer_cfg));
			if (cfg_we) begin
				case (cfg_index)
					REG_TURN_THRESHOLD: steer_cfg.turn_threshold = cfg_wdata[14:0];
					REG_STOP_DISTANCE:  steer_cfg.stop_distance = cfg_wdata;
					REG_FORWARD_SPEED:  steer_cfg.forward_speed = cfg_wdata[14:0];
					default:            steer_cfg.turn_speed = cfg_wdata[14:0];
				endcase
			end
			waiting = due_q.size();
		end
	end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// waypoint steering unit testbench
// drives pose requests in bursts against a stalling result channel, steps
// through register settings while idle and leaves checking to the checker
// ----------------------------------------------------------------------------
module tb;
	import wst_pkg::*;

	localparam int  LATENCY            = CORDIC_STAGES_DEF + 5;
	localparam int  CYCLE_LIMIT        = 400000;
	localparam int  RANDOM_PER_SETTING = 130;
	localparam real PI                 = 3.141592653589793;

	// shapes of random pose request
	localparam int POSE_AIMED   = 0;
	localparam int POSE_UNIFORM = 1;
	localparam int POSE_NEAR    = 2;
	localparam int POSE_EXTREME = 3;
	localparam int POSE_AXIS    = 4;

	// receiver stall patterns
	localparam int RX_OPEN     = 0;
	localparam int RX_COIN     = 1;
	localparam int RX_SPARSE   = 2;
	localparam int RX_PERIODIC = 3;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic [79:0] s_tdata   = '0;
	logic        m_tready  = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [16:0] cfg_wdata = '0;
	logic        s_tready;
	logic        m_tvalid;
	logic [71:0] m_tdata;

	int fail_count;
	int waiting;
	int checked;

	int burst_left   = 0;
	int cur_thr      = 209;
	int cur_stop     = 77;
	int poses_sent   = 0;
	int settings_run = 0;
	int rx_mode      = RX_OPEN;
	int rx_left      = 0;

	always #5 clk = ~clk;

	waypoint_turn_then_drive_steering_unit #(
		.CORDIC_STAGES(CORDIC_STAGES_DEF)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	steering_result_checker i_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.waiting    (waiting),
		.checked    (checked)
	);

	// receiver: switches at random between stall patterns
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(RX_OPEN, RX_PERIODIC);
			rx_left = $urandom_range(16, 300);
		end else begin
			rx_left--;
		end
		case (rx_mode)
			RX_OPEN:   m_tready <= 1'b1;
			RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
			RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
			default:   m_tready <= ((rx_left % 5) < 2);
		endcase
	end

	// watchdog
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("CHECK FAILED");
		$finish;
	end

	function automatic logic [15:0] clamp16(input int v);
		if (v > 32767)
			return 16'h7fff;
		if (v < -32768)
			return 16'h8000;
		return 16'(v);
	endfunction

	function automatic int rand16();
		return int'($urandom_range(0, 65535)) - 32768;
	endfunction

	function automatic int pick_extreme();
		case ($urandom_range(0, 5))
			0:       return -32768;
			1:       return -32767;
			2:       return -1;
			3:       return 0;
			4:       return 1;
			default: return 32767;
		endcase
	endfunction

	// first field in the lowest bits
	function automatic logic [79:0] pack_pose(input int rx, input int ry, input int hd,
			input int gx, input int gy);
		return {16'(gy), 16'(gx), 16'(hd), 16'(ry), 16'(rx)};
	endfunction

	function automatic logic [79:0] random_pose();
		int  roll, kind, rx, ry, hd, gx, gy, dx, dy, radius, spread, bearing_est;
		real theta;
		roll = $urandom_range(0, 99);
		if (roll < 45)
			kind = POSE_AIMED;
		else if (roll < 65)
			kind = POSE_UNIFORM;
		else if (roll < 78)
			kind = POSE_NEAR;
		else if (roll < 90)
			kind = POSE_EXTREME;
		else
			kind = POSE_AXIS;
		rx = rand16();
		ry = rand16();
		hd = rand16();
		gx = rx;
		gy = ry;
		case (kind)
			POSE_AIMED: begin
				// goal in a random direction, heading close to the bearing so that
				// the dead band, the stop distance and both turns all get hit
				theta = (real'($urandom_range(0, 65535)) / 65536.0) * 2.0 * PI;
				if (cur_stop <= 40000 && $urandom_range(0, 1) == 1)
					radius = cur_stop + int'($urandom_range(0, 8)) - 4;
				else if ($urandom_range(0, 1) == 1)
					radius = $urandom_range(0, 600);
				else
					radius = $urandom_range(0, 46000);
				if (radius < 0)
					radius = 0;
				gx = int'($signed(clamp16(rx + int'(real'(radius) * $cos(theta)))));
				gy = int'($signed(clamp16(ry + int'(real'(radius) * $sin(theta)))));
				dx = gx - rx;
				dy = gy - ry;
				if (dx == 0 && dy == 0)
					bearing_est = 0;
				else
					bearing_est = int'($atan2(real'(dy), real'(dx)) * 32768.0 / PI);
				spread = (cur_thr > 20000) ? 20000 : cur_thr + 8;
				hd = bearing_est + int'($urandom_range(0, 2 * spread)) - spread;
			end
			POSE_UNIFORM: begin
				gx = rand16();
				gy = rand16();
			end
			POSE_NEAR: begin
				gx = int'($signed(clamp16(rx + int'($urandom_range(0, 6)) - 3)));
				gy = int'($signed(clamp16(ry + int'($urandom_range(0, 6)) - 3)));
			end
			POSE_EXTREME: begin
				rx = pick_extreme();
				ry = pick_extreme();
				hd = pick_extreme();
				gx = pick_extreme();
				gy = pick_extreme();
			end
			default: begin
				// goal on the robot, or straight along one axis
				case ($urandom_range(0, 2))
					0:       ;
					1:       gy = rand16();
					default: gx = rand16();
				endcase
			end
		endcase
		return pack_pose(rx, ry, hd, gx, gy);
	endfunction

	// one pose request, then either carry on with the burst or leave a gap
	task automatic send_pose(input logic [79:0] p);
		s_tvalid <= 1'b1;
		s_tdata <= p;
		do
			@(posedge clk);
		while (!s_tready);
		poses_sent++;
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
			burst_left = $urandom_range(0, 40);
		end
	endtask

	// hold off new requests until every outstanding result is back
	task automatic drain();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (waiting != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [16:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic apply_setting(input int thr, input int stop, input int fwd, input int turn);
		drain();
		write_reg(REG_TURN_THRESHOLD, 17'(thr));
		write_reg(REG_STOP_DISTANCE, 17'(stop));
		write_reg(REG_FORWARD_SPEED, 17'(fwd));
		write_reg(REG_TURN_SPEED, 17'(turn));
		cur_thr = thr;
		cur_stop = stop;
		settings_run++;
	endtask

	task automatic random_run(input int count);
		int i;
		for (i = 0; i < count; i++) begin
			send_pose(random_pose());
			// occasional pause mid-run until the pipeline is empty
			if (i == count / 2 && $urandom_range(0, 2) == 0)
				drain();
		end
	endtask

	initial begin
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// directed requests at the reset register values
		// goal on the robot: bearing and distance both zero
		send_pose(pack_pose(0, 0, 0, 0, 0));
		// half turn error lands on -32768 and turns right
		send_pose(pack_pose(100, -50, -32768, 100, -50));
		// dead band edges around the threshold
		send_pose(pack_pose(0, 0, -209, 0, 0));
		send_pose(pack_pose(0, 0, -210, 0, 0));
		send_pose(pack_pose(0, 0, 209, 0, 0));
		send_pose(pack_pose(0, 0, 210, 0, 0));
		// full span diagonals, distance near saturation
		send_pose(pack_pose(-32768, -32768, 8192, 32767, 32767));
		send_pose(pack_pose(32767, 32767, -24576, -32768, -32768));
		send_pose(pack_pose(-32768, 32767, -8192, 32767, -32768));
		send_pose(pack_pose(32767, -32768, 24576, -32768, 32767));
		// along the x axis: goal on the axis in the left half plane, then in the right
		send_pose(pack_pose(32767, 0, 32767, -32768, 0));
		send_pose(pack_pose(0, 0, -32768, -1, 0));
		send_pose(pack_pose(-32768, 0, 0, 32767, 0));
		// straight up and down
		send_pose(pack_pose(0, 0, 16384, 0, 32767));
		send_pose(pack_pose(0, 0, -16384, 0, -32768));
		send_pose(pack_pose(0, 0, 16384, 0, 1));
		// distances around the stop distance
		send_pose(pack_pose(0, 0, 0, 76, 0));
		send_pose(pack_pose(0, 0, 0, 77, 0));
		send_pose(pack_pose(0, 0, 0, 78, 0));
		send_pose(pack_pose(0, 0, 0, 1, 0));
		send_pose(pack_pose(-200, 300, 0, 400, 300));
		random_run(RANDOM_PER_SETTING);

		// no dead band, zero stop distance, full speeds
		apply_setting(0, 0, 32767, 32767);
		random_run(RANDOM_PER_SETTING);
		// widest dead band, stop distance above range, zero speeds
		apply_setting(32767, 131071, 0, 0);
		send_pose(pack_pose(0, 0, -32768, 0, 0));
		random_run(RANDOM_PER_SETTING);
		// widest dead band with no stop distance: drive almost always
		apply_setting(32767, 0, 1, 1);
		random_run(RANDOM_PER_SETTING);
		// narrow dead band, stop distance at full range
		apply_setting(1, 92682, 32767, 0);
		random_run(RANDOM_PER_SETTING);
		// back to the power-up values
		apply_setting(209, 77, 179, 205);
		random_run(RANDOM_PER_SETTING);
		repeat (2) begin
			apply_setting(($urandom_range(0, 1) == 1) ? $urandom_range(0, 1500)
					: $urandom_range(0, 32767),
				($urandom_range(0, 1) == 1) ? $urandom_range(0, 2000)
					: $urandom_range(0, 92682),
				$urandom_range(0, 32767), $urandom_range(0, 32767));
			random_run(RANDOM_PER_SETTING);
		end

		drain();
		repeat (LATENCY * 2) @(negedge clk);

		$display("%0d pose requests sent, %0d results compared, %0d register settings",
			poses_sent, checked, settings_run + 1);
		$display("covered dead band edges, half turn, goal on robot, span extremes, stalls");
		if (fail_count == 0 && waiting == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
